// ----- rtl/core/msb_pkg.sv -----
// msb_pkg: shared types, codes and defaults for the multi stack bank.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package msb_pkg;

	localparam int DEF_NUM_STACKS  = 4;
	localparam int DEF_STACK_DEPTH = 16;

	localparam logic [1:0] KIND_PUSH = 2'd0;
	localparam logic [1:0] KIND_POP  = 2'd1;
	localparam logic [1:0] KIND_PEEK = 2'd2;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic [31:0] EMPTY_WORD = 32'hFFFF_FFFF;

	localparam logic       REG_ENTRIES   = 1'b0;
	localparam logic [4:0] ENTRIES_RESET = 5'd16;

	typedef enum logic {
		S_IDLE,
		S_RESULT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic load_out;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/core/msb_regs.sv -----
// msb_regs: APB-style configuration register (stack capacity).
// Depends on msb_pkg.
`timescale 1ns / 1ps
module msb_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [4:0]  entries_per_stack
);
	import msb_pkg::*;

	logic [4:0] entries_q;
	logic       hit;

	assign hit    = (paddr[2] == REG_ENTRIES);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= ENTRIES_RESET;
		end else if (psel && penable && pwrite && hit) begin
			entries_q <= pwdata[4:0];
		end
	end

	assign prdata            = hit ? {27'd0, entries_q} : 32'd0;
	assign entries_per_stack = entries_q;

endmodule

// ----- rtl/core/msb_ctrl.sv -----
// msb_ctrl: sequencer for one operation at a time (accept, then result).
// Depends on msb_pkg.
`timescale 1ns / 1ps
module msb_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  msb_pkg::sts_t   sts,
	output msb_pkg::cmd_t   cmd
);
	import msb_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.accept   = 1'b0;
		cmd.load_out = 1'b0;
		in_stall     = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				// wait here until the output register can take the word
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ----- rtl/core/msb_dpath.sv -----
// msb_dpath: fill counts, shared entry memory and output register.
// Depends on msb_pkg; driven by msb_ctrl commands.
`timescale 1ns / 1ps
module msb_dpath #(
	parameter int NUM_STACKS  = msb_pkg::DEF_NUM_STACKS,
	parameter int STACK_DEPTH = msb_pkg::DEF_STACK_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  msb_pkg::cmd_t        cmd,
	output msb_pkg::sts_t        sts,
	input  logic [4:0]           entries_per_stack,
	input  logic [1:0]           kind,
	input  logic [1:0]           stack_select,
	input  logic signed [31:0]   push_value,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [31:0]   read_value,
	output logic [1:0]           status
);
	import msb_pkg::*;

	localparam int SW    = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
	localparam int CW    = $clog2(STACK_DEPTH + 1);
	localparam int WORDS = NUM_STACKS * STACK_DEPTH;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

	logic [CW-1:0]  fill_q [NUM_STACKS];
	logic [31:0]    mem [WORDS];

	logic [31:0]    sel32, n32, lim32, base32, waddr32, raddr32;
	logic [SW-1:0]  sel_idx;
	logic [CW-1:0]  n;
	logic           in_range, is_push, is_rd, push_ok, rd_ok;
	logic [1:0]     st_d;

	logic [1:0]     st_s1;
	logic           use_mem_s1;
	logic [31:0]    rdata_q;
	logic           out_valid_q;
	logic [31:0]    out_value_q;
	logic [1:0]     out_status_q;

	assign sel32    = 32'(stack_select);
	assign sel_idx  = sel32[SW-1:0];
	assign in_range = (sel32 < 32'(NUM_STACKS));
	assign n        = in_range ? fill_q[sel_idx] : '0;
	assign n32      = 32'(n);
	// capacity above the built depth acts as the built depth
	assign lim32    = (32'(entries_per_stack) > 32'(STACK_DEPTH)) ?
	                  32'(STACK_DEPTH) : 32'(entries_per_stack);
	assign base32   = sel32 * 32'(STACK_DEPTH);
	assign waddr32  = base32 + n32;
	assign raddr32  = base32 + n32 - 32'd1;

	assign is_push  = (kind == KIND_PUSH);
	assign is_rd    = (kind == KIND_POP) || (kind == KIND_PEEK);
	assign push_ok  = is_push && in_range && (n32 < lim32);
	assign rd_ok    = is_rd && in_range && (n != '0);

	always_comb begin
		st_d = ST_DONE;
		if (is_push && !push_ok) begin
			st_d = ST_FULL;
		end else if (is_rd && !rd_ok) begin
			st_d = ST_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STACKS; i++) begin
				fill_q[i] <= '0;
			end
		end else if (cmd.accept) begin
			if (push_ok) begin
				fill_q[sel_idx] <= n + CW'(1);
			end else if (rd_ok && (kind == KIND_POP)) begin
				fill_q[sel_idx] <= n - CW'(1);
			end
		end
	end

	// shared entry store, one write and one registered read per word
	always_ff @(posedge clk) begin
		if (cmd.accept && push_ok) begin
			mem[waddr32[AW-1:0]] <= push_value;
		end
		if (cmd.accept && rd_ok) begin
			rdata_q <= mem[raddr32[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			st_s1      <= st_d;
			use_mem_s1 <= rd_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= st_s1;
			if (use_mem_s1) begin
				out_value_q <= rdata_q;
			end else if (st_s1 == ST_EMPTY) begin
				out_value_q <= EMPTY_WORD;
			end else begin
				out_value_q <= 32'd0;
			end
		end
	end

	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;
	assign read_value   = out_value_q;
	assign status       = out_status_q;

endmodule

// ----- rtl/core/multi_stack_bank.sv -----
// multi_stack_bank: top level of the LIFO stack bank.
// Depends on msb_pkg, msb_regs, msb_ctrl, msb_dpath.
//
// Usage:
//  - Input channel (in_valid / in_stall) carries one word per operation:
//    kind (push, pop, peek), stack_select and push_value.
//  - Output channel (out_valid / out_stall) returns one word per
//    operation: read_value and status (done, full, empty).
//  - APB port holds entries_per_stack, the per-stack capacity, at byte
//    address 0; write it only while the block is idle.
//  - A result word is loaded into the output register once that register
//    is free after its input is taken, and waits while a stall holds it.
//  - The next word is not taken until that result is loaded; the operation
//    reads its stack's fill count and issues a registered read of the entry
//    memory on accept, then the result is formed from the read data.
//  - A waiting result sits in the output register; the next input word is
//    taken meanwhile, and its result waits until the output register frees.
//  - Reset empties every stack (fill counts cleared) and sets capacity
//    to 16; memory contents are not cleared and need not be.
//  - A stalled receiver holds read_value and status steady.
`timescale 1ns / 1ps
module multi_stack_bank #(
	parameter int NUM_STACKS  = msb_pkg::DEF_NUM_STACKS,
	parameter int STACK_DEPTH = msb_pkg::DEF_STACK_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// operation words in
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         kind,
	input  logic [1:0]         stack_select,
	input  logic signed [31:0] push_value,
	// result words out
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] read_value,
	output logic [1:0]         status
);
	import msb_pkg::*;

	cmd_t       cmd;
	sts_t       sts;
	logic [4:0] entries_per_stack;

	msb_regs u_regs (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.entries_per_stack (entries_per_stack)
	);

	// sequencer: idle -> result, one operation in flight
	msb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// counts, entry memory and output register
	msb_dpath #(
		.NUM_STACKS  (NUM_STACKS),
		.STACK_DEPTH (STACK_DEPTH)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.entries_per_stack (entries_per_stack),
		.kind              (kind),
		.stack_select      (stack_select),
		.push_value        (push_value),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.read_value        (read_value),
		.status            (status)
	);

endmodule

// ----- sim/multi_stack_bank_tb.sv -----
// multi_stack_bank_tb: self-checking bench for the multi stack bank.
// Depends on msb_pkg and multi_stack_bank; a scoreboard class tracks the
// per-stack fill counts and entries and checks every result word in order.
`timescale 1ns / 1ps
module multi_stack_bank_tb;
	import msb_pkg::*;

	localparam int NUM_STACKS  = DEF_NUM_STACKS;
	localparam int STACK_DEPTH = DEF_STACK_DEPTH;

	// kind code 3 has no operation behind it; the bank answers 0 / done
	localparam logic [1:0] KIND_SPARE = 2'd3;

	// entries_per_stack sits at byte address 4 * its index
	localparam logic [2:0] ADDR_ENTRIES = {REG_ENTRIES, 2'b00};

	localparam int ITEMS_PER_SETTING = 140;
	localparam int HOLD_OFF_CYCLES   = 64;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [1:0]         status;
	} reply_t;

	// Scoreboard: keeps its own copy of the bank, works out the reply for
	// every accepted operation word and checks replies in arrival order.
	class stack_bank_scoreboard;
		logic [4:0]         capacity;
		int                 depth_of [NUM_STACKS];
		logic signed [31:0] words [NUM_STACKS][STACK_DEPTH];
		reply_t             expected_replies [$];
		int                 fails;

		function new();
			capacity = ENTRIES_RESET;
			foreach (depth_of[s]) depth_of[s] = 0;
			fails = 0;
		endfunction

		function void set_capacity(logic [31:0] v);
			capacity = v[4:0];
		endfunction

		function reply_t predict_stack_op(logic [1:0] op, logic [1:0] sel,
				logic signed [31:0] val);
			reply_t r;
			int     lim;
			int     n;
			r.read_value = '0;
			r.status     = ST_DONE;
			// a capacity beyond the built depth acts as the built depth
			lim = (capacity > STACK_DEPTH) ? STACK_DEPTH : capacity;
			n   = depth_of[sel];
			case (op)
				KIND_PUSH: begin
					// also covers a lowered capacity below the current fill
					if (n >= lim) begin
						r.status = ST_FULL;
					end else begin
						words[sel][n] = val;
						depth_of[sel] = n + 1;
					end
				end
				KIND_POP, KIND_PEEK: begin
					if (n == 0) begin
						r.read_value = EMPTY_WORD;
						r.status     = ST_EMPTY;
					end else begin
						r.read_value = words[sel][n - 1];
						if (op == KIND_POP)
							depth_of[sel] = n - 1;
					end
				end
				default: ;
			endcase
			return r;
		endfunction

		function void note_word(logic [1:0] op, logic [1:0] sel, logic signed [31:0] val);
			expected_replies.push_back(predict_stack_op(op, sel, val));
		endfunction

		function void check_reply(logic signed [31:0] rv, logic [1:0] st);
			reply_t want;
			if (expected_replies.size() == 0) begin
				$error("result word with no operation pending: read_value %0d status %0d",
					rv, st);
				fails++;
				return;
			end
			want = expected_replies.pop_front();
			if (rv !== want.read_value) begin
				$error("read_value: expected %0d, actual %0d", want.read_value, rv);
				fails++;
			end
			if (st !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, st);
				fails++;
			end
		endfunction

		function int pending();
			return expected_replies.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         kind;
	logic [1:0]         stack_select;
	logic signed [31:0] push_value;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] read_value;
	logic [1:0]         status;

	stack_bank_scoreboard sb;

	// idle odds in percent per cycle, changed between phases
	int  send_idle_pct;
	int  recv_idle_pct;
	// set by the stimulus to ask the receiver for one long hold-off
	bit  hold_req;

	multi_stack_bank u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.stack_select (stack_select),
		.push_value   (push_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_value   (read_value),
		.status       (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Both handshakes are sampled at the edge, before any of this edge's
	// updates land, so the pre-edge valid/stall pair decides acceptance.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_word(kind, stack_select, push_value);
		if (arst_n && out_valid && !out_stall)
			sb.check_reply(read_value, status);
	end

	// Receiver: random stall at the current odds; on request it holds off
	// for a long counted stretch so the bank backs up into in_stall.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Offer one operation word and return right after the edge that takes it.
	// in_valid is left high; the next call or settle() decides its next value.
	task automatic send_word(input logic [1:0] op, input logic [1:0] sel,
			input logic [31:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		kind         <= op;
		stack_select <= sel;
		push_value   <= val;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid and wait until every reply is back, plus some slack,
	// so the bank is idle for a register write.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle; pready is always high.
	task automatic write_capacity(input logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_ENTRIES;
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_capacity(v);
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin send_idle_pct = 7;  recv_idle_pct = 88; end
			1: begin send_idle_pct = 88; recv_idle_pct = 7;  end
			default: begin send_idle_pct = 0; recv_idle_pct = 0; end
		endcase
	endtask

	// Random operations in bursts with a push share of 25, 50 or 80 percent,
	// so stacks both drain to empty and climb to full.
	task automatic run_random(input int count);
		int          push_pct;
		int          r;
		logic [1:0]  op;
		logic [31:0] val;
		push_pct = 50;
		for (int i = 0; i < count; i++) begin
			if (i % 35 == 0) begin
				case ($urandom_range(2))
					0: push_pct = 25;
					1: push_pct = 50;
					default: push_pct = 80;
				endcase
			end
			r = $urandom_range(99);
			if (r < 3)
				op = KIND_SPARE;
			else if (r < 3 + push_pct * 97 / 100)
				op = KIND_PUSH;
			else
				op = $urandom_range(1) ? KIND_POP : KIND_PEEK;
			case ($urandom_range(9))
				0: val = 32'h8000_0000;
				1: val = 32'h7FFF_FFFF;
				2: val = 32'hFFFF_FFFF;
				3: val = 32'h0000_0000;
				default: val = $urandom;
			endcase
			send_word(op, 2'($urandom_range(NUM_STACKS - 1)), val);
		end
	endtask

	// Capacity per phase: reset value first, then above build, lowered
	// below fill, zero, one, and a few in-between values.
	int caps [9] = '{16, 31, 3, 0, 1, 16, 9, 2, 20};

	initial begin
		sb = new();
		arst_n       <= 1'b0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		in_valid     <= 1'b0;
		kind         <= KIND_PUSH;
		stack_select <= '0;
		push_value   <= '0;
		hold_req      = 1'b0;
		set_idling(0);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty reads, spare kind, extreme values, LIFO order
		send_word(KIND_POP,   2'd0, 32'h1234_5678);
		send_word(KIND_PEEK,  2'd3, 32'h0);
		send_word(KIND_SPARE, 2'd1, 32'hDEAD_BEEF);
		send_word(KIND_PUSH,  2'd0, 32'h7FFF_FFFF);
		send_word(KIND_PUSH,  2'd0, 32'h8000_0000);
		send_word(KIND_PEEK,  2'd0, 32'h0);
		send_word(KIND_POP,   2'd0, 32'h0);
		send_word(KIND_POP,   2'd0, 32'h0);
		send_word(KIND_POP,   2'd0, 32'h0);
		send_word(KIND_PUSH,  2'd3, 32'hFFFF_FFFF);
		send_word(KIND_PUSH,  2'd1, 32'h0000_0000);
		send_word(KIND_PUSH,  2'd2, 32'hA5A5_A5A5);
		send_word(KIND_PEEK,  2'd3, 32'h0);
		send_word(KIND_POP,   2'd1, 32'h0);
		send_word(KIND_POP,   2'd2, 32'h0);
		send_word(KIND_SPARE, 2'd3, 32'h5A5A_5A5A);
		send_word(KIND_POP,   2'd3, 32'h0);

		// three idling modes, three capacity settings each
		for (int p = 0; p < 9; p++) begin
			if (p > 0) begin
				settle();
				write_capacity(caps[p]);
			end
			set_idling(p / 3);
			if (p == 0)
				hold_req = 1'b1;
			run_random(ITEMS_PER_SETTING);
		end

		settle();
		repeat (10) @(posedge clk);
		if (sb.fails == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// watchdog: far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/msb_pkg.sv
rtl/core/msb_regs.sv
rtl/core/msb_ctrl.sv
rtl/core/msb_dpath.sv
rtl/core/multi_stack_bank.sv
sim/multi_stack_bank_tb.sv
